>>> rtl/blso_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// blso_pkg
// Shared constants, types and coefficient table of the band-limited square
// oscillator.
// ---------------------------------------------------------------------------
package blso_pkg;

    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int PHASE_BITS  = 24;
    localparam int HARM_BITS   = 13;
    localparam int SAMPLE_BITS = 17;
    localparam int QUEUE_DEPTH = 2;

    // Datapath widths.
    localparam int X_BITS   = 48;   // scaled triangle, signed Q.33 cycles
    localparam int OP_BITS  = 40;   // multiplier operands
    localparam int RES_BITS = 48;   // multiplier result
    localparam int U_BITS   = 33;   // sine argument, fraction of a cycle
    localparam int Y_BITS   = 28;   // folded sine argument, Q.28
    localparam int Q_BITS   = 28;   // signed divider quotient
    localparam int QF       = 28;

    // Configuration port.
    localparam int CFG_ADDR_BITS  = 5;
    localparam int REG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [REG_IDX_BITS-1:0] REG_PHASE_INC_BASE = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HARM_BASE      = 3'd4;

    // Sine polynomial coefficients, Q.28.
    localparam logic signed [OP_BITS-1:0] COEF_A = 40'sd1686629674;
    localparam logic signed [OP_BITS-1:0] COEF_B = -40'sd11097566020;
    localparam logic signed [OP_BITS-1:0] COEF_C = 40'sd21904602738;
    localparam logic signed [OP_BITS-1:0] COEF_D = -40'sd20548675717;
    localparam logic signed [OP_BITS-1:0] COEF_E = 40'sd10613053722;

    // round(2^28/(2pi)) times 2^33, dividend of the reciprocal.
    localparam int DIV_NUM_BITS = 59;
    localparam logic [DIV_NUM_BITS-1:0] DIV_NUM = {26'd42722830, 33'd0};
    // round(2^20/(1+1/pi)).
    localparam logic signed [OP_BITS-1:0] INVPI1_Q20 = 40'sd795394;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_X,
        BK_BR,
        BK_DIV,
        BK_INV2,
        SIN_Y,
        SIN_Y2,
        SIN_H,
        SIN_F,
        BK_P1,
        BK_P2,
        BK_V,
        BK_NEXT,
        BK_DONE
    } t_bk_state;

    typedef enum logic [1:0] {
        RET_SMALL,
        RET_S1,
        RET_S2
    } t_ret;

    typedef struct packed {
        logic                       mul_start;
        logic signed [OP_BITS-1:0]  mul_a;
        logic signed [OP_BITS-1:0]  mul_b;
        logic                       mul_shr33;
        logic                       div_start;
        logic signed [X_BITS-1:0]   div_x;
    } t_mdu_req;

    typedef struct packed {
        logic                       mul_busy;
        logic                       mul_done;
        logic signed [RES_BITS-1:0] mul_res;
        logic                       div_busy;
        logic                       div_done;
        logic signed [Q_BITS-1:0]   div_q;
    } t_mdu_rsp;

    // Horner coefficients after the leading one, in evaluation order.
    function automatic logic signed [OP_BITS-1:0] horner_coef(input logic [1:0] k);
        logic signed [OP_BITS-1:0] c;
        case (k)
            2'd0:    c = COEF_D;
            2'd1:    c = COEF_C;
            2'd2:    c = COEF_B;
            default: c = COEF_A;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/blso_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// blso_queue
// Small register FIFO between the front end and the sample engine.
// ---------------------------------------------------------------------------
module blso_queue #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule
`default_nettype wire

>>> rtl/blso_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// blso_front
// Takes tick beats, drops the empty ones and advances the lane phase
// accumulators, queueing the new phases for the sample engine.
// ---------------------------------------------------------------------------
module blso_front (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_valid,
    output logic                                             o_ready,
    input  wire logic                                        i_tick,
    input  wire logic [blso_pkg::PHASE_BITS-1:0]             i_phase_inc [blso_pkg::LANES],
    input  wire logic                                        i_q_full,
    output logic                                             o_q_push,
    output logic [blso_pkg::LANES*blso_pkg::PHASE_BITS-1:0]  o_q_data
);
    logic [blso_pkg::PHASE_BITS-1:0] r_phase [blso_pkg::LANES];
    logic [blso_pkg::PHASE_BITS-1:0] n_phase [blso_pkg::LANES];

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full && i_tick;

    always_comb begin
        for (int l = 0; l < blso_pkg::LANES; l++) begin
            // The accumulator wraps modulo one cycle by its width alone.
            n_phase[l] = r_phase[l] + i_phase_inc[l];
            o_q_data[l*blso_pkg::PHASE_BITS +: blso_pkg::PHASE_BITS] = n_phase[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < blso_pkg::LANES; l++) begin
                r_phase[l] <= '0;
            end
        end else if (o_q_push) begin
            for (int l = 0; l < blso_pkg::LANES; l++) begin
                r_phase[l] <= n_phase[l];
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/blso_mdu.sv
`default_nettype none
// ---------------------------------------------------------------------------
// blso_mdu
// Shared multi-cycle multiplier (14-bit digits, truncating fixed-point
// shift) and 27-step restoring divider for the reciprocal 1/(2 pi x).
// ---------------------------------------------------------------------------
module blso_mdu (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire blso_pkg::t_mdu_req  i_req,
    output blso_pkg::t_mdu_rsp       o_rsp
);
    localparam int OPB   = blso_pkg::OP_BITS;
    localparam int DIG   = 14;
    localparam int NDIG  = 3;
    localparam int MAG   = DIG * NDIG;
    localparam int ACC_W = MAG + OPB;
    localparam int XB    = blso_pkg::X_BITS;
    localparam int QB    = blso_pkg::Q_BITS;
    localparam int QSTEPS = QB - 1;
    localparam int NUMB  = blso_pkg::DIV_NUM_BITS;
    localparam int DSH_W = XB + QSTEPS - 1;

    // Multiplier.
    logic             r_mul_busy, r_mul_done;
    logic [1:0]       r_mul_cnt;
    logic [MAG-1:0]   r_ma;
    logic [OPB-1:0]   r_mb;
    logic             r_mul_neg, r_mul_shr33;
    logic [ACC_W-1:0] r_acc;
    logic [OPB-1:0]   w_abs_a, w_abs_b;
    logic [DIG+OPB-1:0] w_pp;
    logic [ACC_W-1:0] w_shifted;
    logic [blso_pkg::RES_BITS-1:0] w_mag;

    assign w_abs_a = i_req.mul_a[OPB-1] ? (~i_req.mul_a + 1'b1) : i_req.mul_a;
    assign w_abs_b = i_req.mul_b[OPB-1] ? (~i_req.mul_b + 1'b1) : i_req.mul_b;
    assign w_pp    = r_ma[MAG-1 -: DIG] * r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_done <= 1'b0;
            r_mul_cnt  <= '0;
        end else begin
            r_mul_done <= r_mul_busy && (r_mul_cnt == 2'd0);
            if (i_req.mul_start) begin
                r_mul_busy <= 1'b1;
                r_mul_cnt  <= 2'(NDIG - 1);
            end else if (r_mul_busy) begin
                r_mul_cnt <= r_mul_cnt - 1'b1;
                if (r_mul_cnt == 2'd0) begin
                    r_mul_busy <= 1'b0;
                end
            end
        end
    end

    // Digits go in from the top, so the partial sum only ever shifts by one digit.
    always_ff @(posedge i_clk) begin
        if (i_req.mul_start) begin
            r_ma        <= MAG'(w_abs_a);
            r_mb        <= w_abs_b;
            r_mul_neg   <= i_req.mul_a[OPB-1] ^ i_req.mul_b[OPB-1];
            r_mul_shr33 <= i_req.mul_shr33;
            r_acc       <= '0;
        end else if (r_mul_busy) begin
            r_acc <= (r_acc << DIG) + ACC_W'(w_pp);
            r_ma  <= r_ma << DIG;
        end
    end

    assign w_shifted = r_mul_shr33 ? (r_acc >> 33) : (r_acc >> blso_pkg::QF);
    assign w_mag     = w_shifted[blso_pkg::RES_BITS-1:0];

    // Divider: quotient is known to stay below 2^27 since |x| >= 2^32.
    logic             r_div_busy, r_div_done;
    logic [4:0]       r_div_cnt;
    logic [NUMB-1:0]  r_rem;
    logic [DSH_W-1:0] r_dsh;
    logic [QSTEPS-1:0] r_q;
    logic             r_div_neg;
    logic [XB-1:0]    w_abs_x;
    logic             w_ge;

    assign w_abs_x = i_req.div_x[XB-1] ? (~i_req.div_x + 1'b1) : i_req.div_x;
    assign w_ge    = (DSH_W'(r_rem) >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_div_done <= r_div_busy && (r_div_cnt == 5'd0);
            if (i_req.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= 5'(QSTEPS - 1);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - 1'b1;
                if (r_div_cnt == 5'd0) begin
                    r_div_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.div_start) begin
            r_rem     <= blso_pkg::DIV_NUM;
            r_dsh     <= {w_abs_x, (QSTEPS-1)'(0)};
            r_q       <= '0;
            r_div_neg <= i_req.div_x[XB-1];
        end else if (r_div_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[NUMB-1:0];
            end
            r_q   <= {r_q[QSTEPS-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    always_comb begin
        o_rsp.mul_busy = r_mul_busy;
        o_rsp.mul_done = r_mul_done;
        o_rsp.mul_res  = r_mul_neg ? -$signed(w_mag) : $signed(w_mag);
        o_rsp.div_busy = r_div_busy;
        o_rsp.div_done = r_div_done;
        o_rsp.div_q    = r_div_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    end

endmodule
`default_nettype wire

>>> rtl/blso_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// blso_back
// Sample engine: works through the lanes of one queued phase set, folding
// the phase to a scaled triangle and evaluating the sine-integral form on
// the shared multiply/divide unit, then hands the four samples to the
// output register.
// ---------------------------------------------------------------------------
module blso_back (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_q_valid,
    input  wire logic [blso_pkg::LANES*blso_pkg::PHASE_BITS-1:0] i_q_data,
    output logic                                                 o_q_pop,
    input  wire logic [blso_pkg::HARM_BITS-1:0]                  i_harm [blso_pkg::LANES],
    output blso_pkg::t_mdu_req                                   o_mdu_req,
    input  wire blso_pkg::t_mdu_rsp                              i_mdu_rsp,
    output logic                                                 o_valid,
    input  wire logic                                            i_ready,
    output logic signed [blso_pkg::SAMPLE_BITS-1:0]              o_sample [blso_pkg::LANES]
);
    localparam int PB   = blso_pkg::PHASE_BITS;
    localparam int HB   = blso_pkg::HARM_BITS;
    localparam int XB   = blso_pkg::X_BITS;
    localparam int OPB  = blso_pkg::OP_BITS;
    localparam int RB   = blso_pkg::RES_BITS;
    localparam int UB   = blso_pkg::U_BITS;
    localparam int SB   = blso_pkg::SAMPLE_BITS;
    localparam int LW   = blso_pkg::LANE_W;
    localparam int X_SHIFT = 33 - PB;
    localparam logic signed [XB-1:0] X_HALF  = 48'sd4294967296;
    localparam logic signed [RB-1:0] Q_ONE   = 48'sd268435456;
    localparam logic [UB-1:0]        U_QTR   = 33'h080000000;
    localparam logic [UB-1:0]        U_3QTR  = 33'h180000000;
    localparam logic signed [UB+1:0] Y_HALF  = 35'sh100000000;
    localparam logic signed [UB+1:0] Y_ONE   = 35'sh200000000;
    localparam logic signed [RB-1:0] SMP_MAX = 48'sd65535;
    localparam logic signed [RB-1:0] SMP_MIN = -48'sd65536;

    function automatic logic signed [SB-1:0] sat_sample(input logic signed [RB-1:0] v);
        logic signed [SB-1:0] s;
        if (v > SMP_MAX) begin
            s = SMP_MAX[SB-1:0];
        end else if (v < SMP_MIN) begin
            s = SMP_MIN[SB-1:0];
        end else begin
            s = v[SB-1:0];
        end
        return s;
    endfunction

    blso_pkg::t_bk_state r_state, n_state;
    blso_pkg::t_ret      r_ret;

    logic [LW-1:0]                r_lane;
    logic signed [XB-1:0]         r_x;
    logic [UB-1:0]                r_u;
    logic signed [blso_pkg::Y_BITS-1:0] r_y;
    logic signed [OPB-1:0]        r_y2;
    logic [1:0]                   r_k;
    logic signed [blso_pkg::Q_BITS-1:0] r_inv;
    logic signed [OPB-1:0]        r_inv2;
    logic signed [OPB-1:0]        r_p1;
    logic signed [SB-1:0]         r_samp [blso_pkg::LANES];
    logic                         r_out_valid;
    logic signed [SB-1:0]         r_out [blso_pkg::LANES];

    logic                         w_mul_done, w_div_done, w_out_load, w_small;
    logic signed [RB-1:0]         w_res;
    logic [PB-1:0]                w_phase;
    logic signed [PB+1:0]         w_p, w_d, w_tri;
    logic signed [HB:0]           w_n;
    logic signed [PB+HB+2:0]      w_tn;
    logic signed [UB+1:0]         w_yq33, w_ytz;
    logic signed [OPB-1:0]        w_tnew;
    logic [RB-1:0]                w_abs_res;
    logic signed [RB-1:0]         w_small_v;
    logic signed [RB-1:0]         w_sg, w_f;

    assign w_mul_done = i_mdu_rsp.mul_done;
    assign w_div_done = i_mdu_rsp.div_done;
    assign w_res      = i_mdu_rsp.mul_res;

    // Triangle fold and scaling by the harmonic count.
    assign w_phase = i_q_data[r_lane*PB +: PB];
    assign w_p     = $signed({2'b00, w_phase});
    assign w_d     = (w_p >= (PB+2)'(1 << (PB-1))) ? w_p - (PB+2)'(1 << (PB-1))
                                                   : (PB+2)'(1 << (PB-1)) - w_p;
    assign w_tri   = (PB+2)'(1 << (PB-1)) - (w_d <<< 1);
    assign w_n     = (i_harm[r_lane] == '0) ? (HB+1)'(1) : $signed({1'b0, i_harm[r_lane]});
    assign w_tn    = w_tri * w_n;
    assign w_small = (r_x > -X_HALF) && (r_x < X_HALF);

    // Fold the sine argument into a quarter cycle, then drop five bits
    // rounding toward zero.
    always_comb begin
        if (r_u < U_QTR) begin
            w_yq33 = $signed({2'b00, r_u});
        end else if (r_u < U_3QTR) begin
            w_yq33 = Y_HALF - $signed({2'b00, r_u});
        end else begin
            w_yq33 = $signed({2'b00, r_u}) - Y_ONE;
        end
        w_ytz = (w_yq33 < 0) ? ((w_yq33 + 35'sd31) >>> 5) : (w_yq33 >>> 5);
    end

    assign w_tnew    = blso_pkg::horner_coef(r_k) + w_res[OPB-1:0];
    assign w_abs_res = w_res[RB-1] ? -w_res : w_res;
    assign w_small_v = w_res[RB-1] ? -$signed(w_abs_res >> 13) : $signed(w_abs_res >> 13);
    assign w_sg      = r_x[XB-1] ? -Q_ONE : Q_ONE;
    assign w_f       = w_sg - (RB'(r_p1) + w_res);
    assign w_out_load = (r_state == blso_pkg::BK_DONE) && (!r_out_valid || i_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            blso_pkg::BK_IDLE: if (i_q_valid) n_state = blso_pkg::BK_X;
            blso_pkg::BK_X:    n_state = blso_pkg::BK_BR;
            blso_pkg::BK_BR:   n_state = w_small ? blso_pkg::SIN_Y : blso_pkg::BK_DIV;
            blso_pkg::BK_DIV:  if (w_div_done) n_state = blso_pkg::BK_INV2;
            blso_pkg::BK_INV2: if (w_mul_done) n_state = blso_pkg::SIN_Y;
            blso_pkg::SIN_Y:   n_state = blso_pkg::SIN_Y2;
            blso_pkg::SIN_Y2:  if (w_mul_done) n_state = blso_pkg::SIN_H;
            blso_pkg::SIN_H: begin
                if (w_mul_done && r_k == 2'd3) n_state = blso_pkg::SIN_F;
            end
            blso_pkg::SIN_F: begin
                if (w_mul_done) begin
                    case (r_ret)
                        blso_pkg::RET_S1: n_state = blso_pkg::BK_P1;
                        blso_pkg::RET_S2: n_state = blso_pkg::BK_P2;
                        default:          n_state = blso_pkg::BK_NEXT;
                    endcase
                end
            end
            blso_pkg::BK_P1:   if (w_mul_done) n_state = blso_pkg::SIN_Y;
            blso_pkg::BK_P2:   if (w_mul_done) n_state = blso_pkg::BK_V;
            blso_pkg::BK_V:    if (w_mul_done) n_state = blso_pkg::BK_NEXT;
            blso_pkg::BK_NEXT: begin
                n_state = (r_lane == LW'(blso_pkg::LANES - 1)) ? blso_pkg::BK_DONE
                                                               : blso_pkg::BK_X;
            end
            blso_pkg::BK_DONE: if (w_out_load) n_state = blso_pkg::BK_IDLE;
            default:           n_state = blso_pkg::BK_IDLE;
        endcase
    end

    // Requests to the multiply/divide unit.
    always_comb begin
        o_mdu_req           = '0;
        o_mdu_req.div_x     = r_x;
        o_q_pop             = w_out_load;
        case (r_state)
            blso_pkg::BK_BR: begin
                o_mdu_req.div_start = !w_small;
            end
            blso_pkg::BK_DIV: begin
                o_mdu_req.mul_start = w_div_done;
                o_mdu_req.mul_a     = OPB'(i_mdu_rsp.div_q);
                o_mdu_req.mul_b     = OPB'(i_mdu_rsp.div_q);
            end
            blso_pkg::SIN_Y: begin
                o_mdu_req.mul_start = 1'b1;
                o_mdu_req.mul_a     = OPB'(w_ytz);
                o_mdu_req.mul_b     = OPB'(w_ytz);
            end
            blso_pkg::SIN_Y2: begin
                o_mdu_req.mul_start = w_mul_done;
                o_mdu_req.mul_a     = w_res[OPB-1:0];
                o_mdu_req.mul_b     = blso_pkg::COEF_E;
            end
            blso_pkg::SIN_H: begin
                o_mdu_req.mul_start = w_mul_done;
                o_mdu_req.mul_a     = (r_k == 2'd3) ? OPB'(r_y) : r_y2;
                o_mdu_req.mul_b     = w_tnew;
            end
            blso_pkg::SIN_F: begin
                o_mdu_req.mul_start = w_mul_done && (r_ret != blso_pkg::RET_SMALL);
                o_mdu_req.mul_a     = w_res[OPB-1:0];
                o_mdu_req.mul_b     = (r_ret == blso_pkg::RET_S1) ? OPB'(r_inv) : r_inv2;
            end
            blso_pkg::BK_P2: begin
                o_mdu_req.mul_start = w_mul_done;
                o_mdu_req.mul_a     = w_f[OPB-1:0];
                o_mdu_req.mul_b     = blso_pkg::INVPI1_Q20;
                o_mdu_req.mul_shr33 = 1'b1;
            end
            default: begin
                o_mdu_req.mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blso_pkg::BK_IDLE;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == blso_pkg::BK_NEXT) begin
                r_lane <= r_lane + 1'b1;
            end else if (r_state == blso_pkg::BK_DONE) begin
                r_lane <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            blso_pkg::BK_X: begin
                r_x <= XB'(w_tn) <<< X_SHIFT;
            end
            blso_pkg::BK_BR: begin
                r_u   <= r_x[UB:1];
                r_ret <= blso_pkg::RET_SMALL;
            end
            blso_pkg::BK_DIV: begin
                if (w_div_done) r_inv <= i_mdu_rsp.div_q;
            end
            blso_pkg::BK_INV2: begin
                if (w_mul_done) begin
                    r_inv2 <= w_res[OPB-1:0];
                    r_u    <= r_x[UB-1:0] + U_QTR;
                    r_ret  <= blso_pkg::RET_S1;
                end
            end
            blso_pkg::SIN_Y: begin
                r_y <= w_ytz[blso_pkg::Y_BITS-1:0];
            end
            blso_pkg::SIN_Y2: begin
                if (w_mul_done) begin
                    r_y2 <= w_res[OPB-1:0];
                    r_k  <= 2'd0;
                end
            end
            blso_pkg::SIN_H: begin
                if (w_mul_done) r_k <= r_k + 1'b1;
            end
            blso_pkg::SIN_F: begin
                if (w_mul_done && r_ret == blso_pkg::RET_SMALL) begin
                    r_samp[r_lane] <= sat_sample(w_small_v);
                end
            end
            blso_pkg::BK_P1: begin
                if (w_mul_done) begin
                    r_p1  <= w_res[OPB-1:0];
                    r_u   <= r_x[UB-1:0];
                    r_ret <= blso_pkg::RET_S2;
                end
            end
            blso_pkg::BK_V: begin
                if (w_mul_done) r_samp[r_lane] <= sat_sample(w_res);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (w_out_load) begin
            for (int l = 0; l < blso_pkg::LANES; l++) begin
                r_out[l] <= r_samp[l];
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_out;

endmodule
`default_nettype wire

>>> rtl/band_limited_square_osc.sv
`default_nettype none
// ---------------------------------------------------------------------------
// band_limited_square_osc
// Four-lane band-limited square oscillator using a sine-integral shape,
// with signed Q2.15 saturated samples.
// ---------------------------------------------------------------------------
//  Channel   Signals                              Direction  Beat
//  ticks     i_valid, o_ready, i_tick             in         one tick request
//  samples   o_valid, i_ready, o_sample_lane0..3  out        one sample per lane
//  config    psel, penable, pwrite, paddr, ...    in/out     one register write
//
//  A tick with i_tick high yields one sample beat; a low tick is taken and dropped.
//  The lanes of a beat run one after another on a shared multiplier and a 27-step
//  divider used by lanes whose scaled triangle reaches half a cycle.
//  The queue holds two ticks, the one the engine is working on among them; a stalled
//  output holds the engine only once its next beat is finished. Reset is synchronous
//  and needs no clearing.
// ---------------------------------------------------------------------------
module band_limited_square_osc #(
    parameter int QUEUE_DEPTH = blso_pkg::QUEUE_DEPTH
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic                                     i_tick,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic signed [blso_pkg::SAMPLE_BITS-1:0]       o_sample_lane0,
    output logic signed [blso_pkg::SAMPLE_BITS-1:0]       o_sample_lane1,
    output logic signed [blso_pkg::SAMPLE_BITS-1:0]       o_sample_lane2,
    output logic signed [blso_pkg::SAMPLE_BITS-1:0]       o_sample_lane3,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [blso_pkg::CFG_ADDR_BITS-1:0]       paddr,
    input  wire logic [blso_pkg::CFG_DATA_BITS-1:0]       pwdata,
    output logic [blso_pkg::CFG_DATA_BITS-1:0]            prdata,
    output logic                                          pready
);
    localparam int QW = blso_pkg::LANES * blso_pkg::PHASE_BITS;

    logic [blso_pkg::PHASE_BITS-1:0] r_phase_inc [blso_pkg::LANES];
    logic [blso_pkg::HARM_BITS-1:0]  r_harm      [blso_pkg::LANES];
    logic [blso_pkg::REG_IDX_BITS-1:0] w_idx;
    logic [blso_pkg::LANE_W-1:0]     w_lane;
    logic                            w_wr;

    logic          w_q_push, w_q_pop, w_q_full, w_q_empty;
    logic [QW-1:0] w_q_wdata, w_q_rdata;
    blso_pkg::t_mdu_req w_mdu_req;
    blso_pkg::t_mdu_rsp w_mdu_rsp;
    logic signed [blso_pkg::SAMPLE_BITS-1:0] w_sample [blso_pkg::LANES];

    assign pready = 1'b1;
    assign w_idx  = paddr[blso_pkg::CFG_ADDR_BITS-1:2];
    assign w_lane = w_idx[blso_pkg::LANE_W-1:0];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < blso_pkg::LANES; l++) begin
                r_phase_inc[l] <= '0;
                r_harm[l]      <= blso_pkg::HARM_BITS'(1);
            end
        end else if (w_wr) begin
            if (w_idx >= blso_pkg::REG_HARM_BASE) begin
                r_harm[w_lane] <= pwdata[blso_pkg::HARM_BITS-1:0];
            end else begin
                r_phase_inc[w_lane] <= pwdata[blso_pkg::PHASE_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (w_idx >= blso_pkg::REG_HARM_BASE) begin
            prdata = blso_pkg::CFG_DATA_BITS'(r_harm[w_lane]);
        end else begin
            prdata = blso_pkg::CFG_DATA_BITS'(r_phase_inc[w_lane]);
        end
    end

    blso_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_tick      (i_tick),
        .i_phase_inc (r_phase_inc),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata)
    );

    blso_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    blso_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mdu_req),
        .o_rsp   (w_mdu_rsp)
    );

    blso_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!w_q_empty),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .i_harm    (r_harm),
        .o_mdu_req (w_mdu_req),
        .i_mdu_rsp (w_mdu_rsp),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_sample  (w_sample)
    );

    assign o_sample_lane0 = w_sample[0];
    assign o_sample_lane1 = w_sample[1];
    assign o_sample_lane2 = w_sample[2];
    assign o_sample_lane3 = w_sample[3];

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("sample engine popped an empty queue");

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdu_req.mul_start |-> !w_mdu_rsp.mul_busy)
        else $error("multiplier started while busy");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdu_req.div_start |-> (!w_mdu_rsp.div_busy && !w_mdu_rsp.mul_busy))
        else $error("divider started while the arithmetic unit was busy");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

>>> dv/band_limited_square_osc_tb.sv
// ---------------------------------------------------------------------------
// band_limited_square_osc_tb
// Self-checking testbench for the four-lane band-limited square oscillator.
// Ticks are driven over a valid/ready channel, and lane registers are
// written over the APB-style port. A fixed-point model of the lanes predicts
// every sample beat. Each beat that the block sends is compared, lane by lane,
// with the oldest prediction.
// ---------------------------------------------------------------------------
module band_limited_square_osc_tb;

    localparam int LANES         = blso_pkg::LANES;
    localparam int PHASE_BITS    = blso_pkg::PHASE_BITS;
    localparam int HARM_BITS     = blso_pkg::HARM_BITS;
    localparam int SAMPLE_BITS   = blso_pkg::SAMPLE_BITS;
    localparam int CFG_ADDR_BITS = blso_pkg::CFG_ADDR_BITS;
    localparam int CFG_DATA_BITS = blso_pkg::CFG_DATA_BITS;
    localparam int REG_PHASE_INC_BASE = int'(blso_pkg::REG_PHASE_INC_BASE);
    localparam int REG_HARM_BASE      = int'(blso_pkg::REG_HARM_BASE);
    localparam longint COEF_A     = longint'(blso_pkg::COEF_A);
    localparam longint COEF_B     = longint'(blso_pkg::COEF_B);
    localparam longint COEF_C     = longint'(blso_pkg::COEF_C);
    localparam longint COEF_D     = longint'(blso_pkg::COEF_D);
    localparam longint COEF_E     = longint'(blso_pkg::COEF_E);
    localparam longint DIV_NUM    = longint'(blso_pkg::DIV_NUM);
    localparam longint INVPI1_Q20 = longint'(blso_pkg::INVPI1_Q20);

    localparam longint XONE = longint'(1) << 33;
    localparam longint QONE = longint'(1) << 28;
    localparam int PHASE_HOLD = 600;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] lane [LANES];
    } t_beat;

    typedef struct {
        bit     tick;
        bit     typed;
        int     lane_val;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_tick = 1'b0;
    logic i_ready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic o_ready, o_valid, pready;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic signed [SAMPLE_BITS-1:0] o_sample_lane0, o_sample_lane1;
    logic signed [SAMPLE_BITS-1:0] o_sample_lane2, o_sample_lane3;

    logic [PHASE_BITS-1:0] step_inc [LANES];
    logic [HARM_BITS-1:0]  harm_cnt [LANES];
    logic [PHASE_BITS-1:0] acc      [LANES];

    t_beat pending_beats [$];
    int    err_cnt = 0;
    int    hold_cycles = 0;
    int    burst_left = 0;

    band_limited_square_osc dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_tick, .o_valid, .i_ready,
        .o_sample_lane0, .o_sample_lane1, .o_sample_lane2, .o_sample_lane3,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    function automatic longint qmul(longint a, longint b);
        return (a * b) / QONE;
    endfunction

    // sin(2 pi u) for u in Q.33 turns, Q.28 result.
    function automatic longint sin_turn(longint u);
        longint f, y, y2, t;
        f = u & (XONE - 1);
        if (f < XONE / 4)
            y = f;
        else if (f < 3 * (XONE / 4))
            y = XONE / 2 - f;
        else
            y = f - XONE;
        y = y / 32;
        y2 = qmul(y, y);
        t = longint'(COEF_E);
        t = longint'(COEF_D) + qmul(y2, t);
        t = longint'(COEF_C) + qmul(y2, t);
        t = longint'(COEF_B) + qmul(y2, t);
        t = longint'(COEF_A) + qmul(y2, t);
        return qmul(y, t);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] osc_sample(
        logic [PHASE_BITS-1:0] ph, logic [HARM_BITS-1:0] harm);
        longint half, p, d, tri_v, x, v, inv, inv2, sg, f, n;
        half = longint'(1) << (PHASE_BITS - 1);
        p = longint'(ph);
        n = (harm == 0) ? 1 : longint'(harm);
        d = (p >= half) ? p - half : half - p;
        tri_v = half - 2 * d;
        x = tri_v * n * 512;
        if (x > -(XONE / 2) && x < XONE / 2) begin
            v = sin_turn(x / 2) / 8192;
        end else begin
            inv = longint'(DIV_NUM) / x;
            inv2 = qmul(inv, inv);
            sg = (x < 0) ? -QONE : QONE;
            f = sg - (qmul(sin_turn(x + XONE / 4), inv) + qmul(sin_turn(x), inv2));
            v = (f * longint'(INVPI1_Q20)) / XONE;
        end
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Advances every lane and returns the predicted beat.
    function automatic t_beat advance_lanes();
        t_beat b;
        for (int i = 0; i < LANES; i++) begin
            acc[i] = acc[i] + step_inc[i];
            b.lane[i] = osc_sample(acc[i], harm_cnt[i]);
        end
        return b;
    endfunction

    task automatic write_reg(int idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = CFG_ADDR_BITS'(4 * idx); pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx < LANES)
            step_inc[idx] = val[PHASE_BITS-1:0];
        else
            harm_cnt[idx - LANES] = val[HARM_BITS-1:0];
    endtask

    task automatic write_lanes(logic [31:0] inc, logic [31:0] harm);
        for (int i = 0; i < LANES; i++) begin
            write_reg(int'(REG_PHASE_INC_BASE) + i, inc);
            write_reg(int'(REG_HARM_BASE) + i, harm);
        end
    endtask

    // Offers one tick; typed rows replace the prediction with a known value.
    task automatic send_tick(bit t, bit typed, int lane_val);
        t_beat b;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_tick = t;
        do @(posedge i_clk); while (!o_ready);
        if (t) begin
            b = advance_lanes();
            if (typed)
                for (int i = 0; i < LANES; i++) b.lane[i] = SAMPLE_BITS'(lane_val);
            pending_beats.push_back(b);
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (PHASE_HOLD) @(posedge i_clk);
    endtask

    // Receiver: random stall pattern, long hold-offs on request.
    initial begin
        int cyc;
        int stall_len;
        cyc = 0;
        stall_len = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 64 == 0) stall_len = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
            if (hold_cycles > 0) begin
                i_ready = 1'b0;
                hold_cycles--;
            end else begin
                i_ready = ((cyc % 8) >= stall_len);
            end
            cyc++;
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        logic signed [SAMPLE_BITS-1:0] got [LANES];
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_sample_lane0, o_sample_lane1, o_sample_lane2, o_sample_lane3};
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected sample beat, expected none, actual %0d %0d %0d %0d",
                         $time, got[0], got[1], got[2], got[3]);
                err_cnt++;
            end else begin
                want = pending_beats.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (got[i] !== want.lane[i]) begin
                        $display("%0t: lane %0d sample mismatch, expected %0d, actual %0d",
                                 $time, i, want.lane[i], got[i]);
                        err_cnt++;
                    end
            end
        end
    end

    initial begin
        #100000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row rows [$];
        for (int i = 0; i < LANES; i++) begin
            step_inc[i] = '0;
            harm_cnt[i] = 1;
            acc[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reset values first, then a quarter-turn step whose
        // first tick lands on the triangle's zero crossing for any count.
        rows = '{'{1'b0, 1'b0, 0}, '{1'b1, 1'b0, 0}, '{1'b1, 1'b0, 0}};
        foreach (rows[k]) send_tick(rows[k].tick, rows[k].typed, rows[k].lane_val);
        drain();
        for (int i = 0; i < LANES; i++) begin
            write_reg(int'(REG_PHASE_INC_BASE) + i, 32'h40_0000);
            write_reg(int'(REG_HARM_BASE) + i, (i == 0) ? 32'd1 : (i == 1) ? 32'd8191 :
                                              (i == 2) ? 32'd0 : 32'd2);
        end
        for (int i = 0; i < LANES; i++) acc[i] = acc[i];
        rows = '{'{1'b1, 1'b1, 0}, '{1'b1, 1'b0, 0}, '{1'b0, 1'b0, 0},
                 '{1'b1, 1'b0, 0}, '{1'b1, 1'b0, 0}, '{1'b1, 1'b0, 0}};
        // The typed row only holds when every accumulator starts at a turn
        // multiple, which the untyped reset ticks above keep at zero.
        foreach (rows[k]) send_tick(rows[k].tick, rows[k].typed, rows[k].lane_val);
        drain();
        write_lanes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++) send_tick(1'b1, 1'b0, 0);
        drain();
        write_lanes(32'h0000_0001, 32'd1);
        for (int k = 0; k < 4; k++) send_tick(k[0], 1'b0, 0);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 5; ph++) begin
            for (int i = 0; i < LANES; i++) begin
                write_reg(int'(REG_PHASE_INC_BASE) + i,
                          (ph == 0) ? 32'h00FF_FFFF : $urandom());
                write_reg(int'(REG_HARM_BASE) + i,
                          (ph == 0) ? 32'd8191 : (ph == 1) ? 32'd0 :
                          (ph == 2) ? $urandom_range(1, 12) : $urandom());
            end
            for (int k = 0; k < 385; k++) begin
                if (ph == 2 && k == 100) hold_cycles = 3000;
                send_tick($urandom_range(0, 4) != 0, 1'b0, 0);
                pace();
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
